// ===== rtl/core/assoc_cache_counter_replacement_defines.svh =====
// ----------------------------------------------------------------------------
// assoc_cache_counter_replacement_defines
// Assertion macros used by the checker file of the cache directory.
// ----------------------------------------------------------------------------
`ifndef ASSOC_CACHE_COUNTER_REPLACEMENT_DEFINES_SVH
`define ASSOC_CACHE_COUNTER_REPLACEMENT_DEFINES_SVH

// check a property outside reset
`define ACR_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// check a property on every edge, reset included
`define ACR_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

// ===== rtl/core/acr_pkg.sv =====
// ----------------------------------------------------------------------------
// acr_pkg
// Types and constants of the associative cache directory.
// ----------------------------------------------------------------------------
`default_nettype none

package acr_pkg;

   localparam int TAG_PORT_BITS   = 20;
   localparam int INDEX_PORT_BITS = 4;
   localparam int MODE_BITS       = 2;
   localparam int LINES_CFG_BITS  = 5;
   localparam int CSR_ADDR_BITS   = 3;
   localparam int CSR_DATA_BITS   = 32;

   localparam logic [MODE_BITS-1:0] MODE_LRU  = 2'd0;
   localparam logic [MODE_BITS-1:0] MODE_LFU  = 2'd1;
   localparam logic [MODE_BITS-1:0] MODE_FIFO = 2'd2;

   localparam logic REG_POLICY_MODE  = 1'b0;
   localparam logic REG_LINES_IN_USE = 1'b1;

   localparam logic [MODE_BITS-1:0]      POLICY_MODE_RESET  = MODE_LRU;
   localparam logic [LINES_CFG_BITS-1:0] LINES_IN_USE_RESET = 5'd16;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_SCAN_END,
      ST_UPDATE,
      ST_UPDATE_END
   } state_type;

   typedef struct packed {
      logic load;
      logic clear_addr;
      logic scan_rd;
      logic upd_rd;
   } dp_cmd_type;

   typedef struct packed {
      logic last;
   } dp_status_type;

endpackage

`default_nettype wire

// ===== rtl/core/acr_ram.sv =====
// ----------------------------------------------------------------------------
// acr_ram
// Generic RAM, one write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module acr_ram #(
   parameter int WIDTH = 36,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== rtl/core/acr_csr.sv =====
// ----------------------------------------------------------------------------
// acr_csr
// Configuration registers: replacement policy and number of active lines.
// ----------------------------------------------------------------------------
`default_nettype none

module acr_csr (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 psel,
   input  wire logic                                 penable,
   input  wire logic                                 pwrite,
   input  wire logic [acr_pkg::CSR_ADDR_BITS-1:0]    paddr,
   input  wire logic [acr_pkg::CSR_DATA_BITS-1:0]    pwdata,
   output logic      [acr_pkg::CSR_DATA_BITS-1:0]    prdata,
   output logic                                      pready,
   output logic      [acr_pkg::MODE_BITS-1:0]        policy_mode,
   output logic      [acr_pkg::LINES_CFG_BITS-1:0]   lines_in_use
);

   import acr_pkg::*;

   logic [MODE_BITS-1:0]      policy_mode_ff, policy_mode_in;
   logic [LINES_CFG_BITS-1:0] lines_in_use_ff, lines_in_use_in;
   logic                      reg_index;
   logic                      wr_strobe;

   assign reg_index = paddr[CSR_ADDR_BITS-1];
   assign wr_strobe = psel && penable && pwrite;
   assign pready    = 1'b1;

   always_comb begin
      policy_mode_in  = policy_mode_ff;
      lines_in_use_in = lines_in_use_ff;
      if (wr_strobe) begin
         case (reg_index)
            REG_POLICY_MODE:  policy_mode_in  = pwdata[MODE_BITS-1:0];
            REG_LINES_IN_USE: lines_in_use_in = pwdata[LINES_CFG_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_index)
         REG_POLICY_MODE:  prdata = CSR_DATA_BITS'(policy_mode_ff);
         REG_LINES_IN_USE: prdata = CSR_DATA_BITS'(lines_in_use_ff);
         default:          prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         policy_mode_ff  <= POLICY_MODE_RESET;
         lines_in_use_ff <= LINES_IN_USE_RESET;
      end else begin
         policy_mode_ff  <= policy_mode_in;
         lines_in_use_ff <= lines_in_use_in;
      end
   end

   assign policy_mode  = policy_mode_ff;
   assign lines_in_use = lines_in_use_ff;

endmodule

`default_nettype wire

// ===== rtl/core/acr_ctrl.sv =====
// ----------------------------------------------------------------------------
// acr_ctrl
// Sequencer: lookup scan over the active lines, then update pass, then result.
// ----------------------------------------------------------------------------
`default_nettype none

module acr_ctrl (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   start,
   output logic                        busy,
   output logic                        rsp_valid,
   output acr_pkg::dp_cmd_type         cmd,
   input  wire acr_pkg::dp_status_type status
);

   import acr_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      busy      = 1'b1;
      rsp_valid = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            busy = 1'b0;
            if (start) begin
               cmd.load = 1'b1;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            cmd.scan_rd = 1'b1;
            if (status.last) begin
               state_in = ST_SCAN_END;
            end
         end
         ST_SCAN_END: begin
            cmd.clear_addr = 1'b1;
            state_in       = ST_UPDATE;
         end
         ST_UPDATE: begin
            cmd.upd_rd = 1'b1;
            if (status.last) begin
               state_in = ST_UPDATE_END;
            end
         end
         ST_UPDATE_END: begin
            rsp_valid = 1'b1;
            state_in  = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

// ===== rtl/core/acr_dp.sv =====
// ----------------------------------------------------------------------------
// acr_dp
// Datapath: line store, valid bits, scan compare and counter update.
// ----------------------------------------------------------------------------
`default_nettype none

module acr_dp #(
   parameter int LINES      = 16,
   parameter int TAG_BITS   = 20,
   parameter int COUNT_BITS = 16
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire acr_pkg::dp_cmd_type                 cmd,
   output acr_pkg::dp_status_type                   status,
   input  wire logic [acr_pkg::TAG_PORT_BITS-1:0]   req_block_tag,
   input  wire logic [acr_pkg::MODE_BITS-1:0]       policy_mode,
   input  wire logic [acr_pkg::LINES_CFG_BITS-1:0]  lines_in_use,
   output logic                                     rsp_hit,
   output logic      [acr_pkg::INDEX_PORT_BITS-1:0] rsp_line_index,
   output logic                                     rsp_evicted_valid,
   output logic      [acr_pkg::TAG_PORT_BITS-1:0]   rsp_evicted_tag
);

   import acr_pkg::*;

   localparam int IDX_W  = $clog2(LINES);
   localparam int WORD_W = TAG_BITS + COUNT_BITS;
   localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

   logic [LINES-1:0]      valid_ff, valid_in;
   logic [TAG_BITS-1:0]   tag_ff, tag_in;
   logic                  lfu_ff, lfu_in;
   logic                  fifo_ff, fifo_in;
   logic [IDX_W-1:0]      last_ff, last_in;
   logic [IDX_W-1:0]      addr_ff, addr_in;
   logic                  s1_scan_ff, s1_upd_ff;
   logic [IDX_W-1:0]      s1_idx_ff;
   logic                  hit_ff, hit_in;
   logic [IDX_W-1:0]      hit_idx_ff, hit_idx_in;
   logic                  empty_ff, empty_in;
   logic [IDX_W-1:0]      empty_idx_ff, empty_idx_in;
   logic [IDX_W-1:0]      best_idx_ff, best_idx_in;
   logic [COUNT_BITS-1:0] best_cnt_ff, best_cnt_in;
   logic [TAG_BITS-1:0]   best_tag_ff, best_tag_in;

   logic [WORD_W-1:0]     rd_data;
   logic [WORD_W-1:0]     wr_data;
   logic                  wr_en;
   logic [TAG_BITS-1:0]   rd_tag;
   logic [COUNT_BITS-1:0] rd_cnt;
   logic                  cur_valid;
   logic [COUNT_BITS-1:0] cur_cnt;
   logic [COUNT_BITS-1:0] cur_sat;
   logic [COUNT_BITS-1:0] scan_cnt;
   logic [COUNT_BITS-1:0] new_cnt;
   logic [TAG_BITS-1:0]   new_tag;
   logic                  better;
   logic                  is_victim;
   logic [IDX_W-1:0]      victim;
   logic [IDX_W-1:0]      last_cfg;

   acr_ram #(
      .WIDTH (WORD_W),
      .DEPTH (LINES)
   ) u_line_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (s1_idx_ff),
      .wr_data (wr_data),
      .rd_en   (cmd.scan_rd || cmd.upd_rd),
      .rd_addr (addr_ff),
      .rd_data (rd_data)
   );

   assign rd_tag    = rd_data[WORD_W-1:COUNT_BITS];
   assign rd_cnt    = rd_data[COUNT_BITS-1:0];
   assign cur_valid = valid_ff[s1_idx_ff];
   assign cur_cnt   = cur_valid ? rd_cnt : '0;
   assign cur_sat   = (cur_cnt == CNT_MAX) ? cur_cnt : cur_cnt + COUNT_BITS'(1);
   assign scan_cnt  = (fifo_ff && cur_valid) ? cur_sat : cur_cnt;
   assign better    = lfu_ff ? (scan_cnt < best_cnt_ff) : (scan_cnt > best_cnt_ff);
   assign victim    = empty_ff ? empty_idx_ff : best_idx_ff;
   assign is_victim = !hit_ff && (s1_idx_ff == victim);

   assign status.last = (addr_ff == last_ff);

   // clamp the active line count to 1..LINES
   always_comb begin
      if (lines_in_use == '0) begin
         last_cfg = '0;
      end else if (32'(lines_in_use) > 32'(LINES)) begin
         last_cfg = IDX_W'(LINES - 1);
      end else begin
         last_cfg = IDX_W'(lines_in_use - LINES_CFG_BITS'(1));
      end
   end

   // new counter and tag of the line coming back in the update pass
   always_comb begin
      new_tag = rd_tag;
      if (fifo_ff) begin
         new_cnt = cur_valid ? cur_sat : cur_cnt;
      end else if (hit_ff && lfu_ff) begin
         new_cnt = (s1_idx_ff == hit_idx_ff) ? cur_sat : cur_cnt;
      end else if (hit_ff) begin
         new_cnt = (s1_idx_ff == hit_idx_ff) ? '0 : (cur_valid ? cur_sat : cur_cnt);
      end else begin
         new_cnt = cur_cnt;
      end
      if (is_victim) begin
         new_tag = tag_ff;
         new_cnt = '0;
      end
   end

   assign wr_en   = s1_upd_ff;
   assign wr_data = {new_tag, new_cnt};

   always_comb begin
      valid_in     = valid_ff;
      tag_in       = tag_ff;
      lfu_in       = lfu_ff;
      fifo_in      = fifo_ff;
      last_in      = last_ff;
      addr_in      = addr_ff;
      hit_in       = hit_ff;
      hit_idx_in   = hit_idx_ff;
      empty_in     = empty_ff;
      empty_idx_in = empty_idx_ff;
      best_idx_in  = best_idx_ff;
      best_cnt_in  = best_cnt_ff;
      best_tag_in  = best_tag_ff;

      if (cmd.load) begin
         tag_in   = TAG_BITS'(req_block_tag);
         lfu_in   = (policy_mode == MODE_LFU);
         fifo_in  = (policy_mode == MODE_FIFO);
         last_in  = last_cfg;
         hit_in   = 1'b0;
         empty_in = 1'b0;
      end

      if (cmd.load || cmd.clear_addr) begin
         addr_in = '0;
      end else if (cmd.scan_rd || cmd.upd_rd) begin
         addr_in = addr_ff + IDX_W'(1);
      end

      if (s1_scan_ff) begin
         if (cur_valid && (rd_tag == tag_ff) && !hit_ff) begin
            hit_in     = 1'b1;
            hit_idx_in = s1_idx_ff;
         end
         if (!cur_valid && !empty_ff) begin
            empty_in     = 1'b1;
            empty_idx_in = s1_idx_ff;
         end
         if ((s1_idx_ff == '0) || better) begin
            best_idx_in = s1_idx_ff;
            best_cnt_in = scan_cnt;
            best_tag_in = rd_tag;
         end
      end

      if (s1_upd_ff && is_victim) begin
         valid_in[s1_idx_ff] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff   <= '0;
         addr_ff    <= '0;
         s1_scan_ff <= 1'b0;
         s1_upd_ff  <= 1'b0;
      end else begin
         valid_ff   <= valid_in;
         addr_ff    <= addr_in;
         s1_scan_ff <= cmd.scan_rd;
         s1_upd_ff  <= cmd.upd_rd;
      end
   end

   always_ff @(posedge clock) begin
      tag_ff       <= tag_in;
      lfu_ff       <= lfu_in;
      fifo_ff      <= fifo_in;
      last_ff      <= last_in;
      s1_idx_ff    <= addr_ff;
      hit_ff       <= hit_in;
      hit_idx_ff   <= hit_idx_in;
      empty_ff     <= empty_in;
      empty_idx_ff <= empty_idx_in;
      best_idx_ff  <= best_idx_in;
      best_cnt_ff  <= best_cnt_in;
      best_tag_ff  <= best_tag_in;
   end

   assign rsp_hit           = hit_ff;
   assign rsp_line_index    = INDEX_PORT_BITS'(hit_ff ? hit_idx_ff : victim);
   assign rsp_evicted_valid = !hit_ff && !empty_ff;
   assign rsp_evicted_tag   = rsp_evicted_valid ? TAG_PORT_BITS'(best_tag_ff) : '0;

endmodule

`default_nettype wire

// ===== rtl/core/assoc_cache_counter_replacement.sv =====
// ----------------------------------------------------------------------------
// assoc_cache_counter_replacement
// Fully associative cache directory with LRU, LFU and FIFO counter replacement.
//
//   channel   ports                               handshake
//   request   req_block_tag                       start && !busy
//   result    rsp_hit, rsp_line_index,            rsp_valid, one cycle
//             rsp_evicted_valid, rsp_evicted_tag
//   config    psel, penable, pwrite, paddr, ...   psel && penable && pwrite
//
// An item runs a lookup scan over the N active lines, one line store read per
// cycle, then an update pass with one read-modify-write per cycle; no new
// request is accepted until busy falls.
// The result strobe comes in the last busy cycle; the receiver cannot stall.
// Reset empties every line and restores policy LRU with 16 active lines.
// ----------------------------------------------------------------------------
`default_nettype none

module assoc_cache_counter_replacement #(
   parameter int LINES      = 16,
   parameter int TAG_BITS   = 20,
   parameter int COUNT_BITS = 16
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                start,
   output logic                                     busy,
   input  wire logic [acr_pkg::TAG_PORT_BITS-1:0]   req_block_tag,
   output logic                                     rsp_valid,
   output logic                                     rsp_hit,
   output logic      [acr_pkg::INDEX_PORT_BITS-1:0] rsp_line_index,
   output logic                                     rsp_evicted_valid,
   output logic      [acr_pkg::TAG_PORT_BITS-1:0]   rsp_evicted_tag,
   input  wire logic                                psel,
   input  wire logic                                penable,
   input  wire logic                                pwrite,
   input  wire logic [acr_pkg::CSR_ADDR_BITS-1:0]   paddr,
   input  wire logic [acr_pkg::CSR_DATA_BITS-1:0]   pwdata,
   output logic      [acr_pkg::CSR_DATA_BITS-1:0]   prdata,
   output logic                                     pready
);

   import acr_pkg::*;

   dp_cmd_type                cmd;
   dp_status_type             status;
   logic [MODE_BITS-1:0]      policy_mode;
   logic [LINES_CFG_BITS-1:0] lines_in_use;

   acr_csr u_csr (
      .clock        (clock),
      .reset        (reset),
      .psel         (psel),
      .penable      (penable),
      .pwrite       (pwrite),
      .paddr        (paddr),
      .pwdata       (pwdata),
      .prdata       (prdata),
      .pready       (pready),
      .policy_mode  (policy_mode),
      .lines_in_use (lines_in_use)
   );

   acr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .cmd       (cmd),
      .status    (status)
   );

   acr_dp #(
      .LINES      (LINES),
      .TAG_BITS   (TAG_BITS),
      .COUNT_BITS (COUNT_BITS)
   ) u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .req_block_tag     (req_block_tag),
      .policy_mode       (policy_mode),
      .lines_in_use      (lines_in_use),
      .rsp_hit           (rsp_hit),
      .rsp_line_index    (rsp_line_index),
      .rsp_evicted_valid (rsp_evicted_valid),
      .rsp_evicted_tag   (rsp_evicted_tag)
   );

endmodule

`default_nettype wire

// ===== rtl/core/acr_checker.sv =====
// ----------------------------------------------------------------------------
// acr_checker
// Port-level checks of the cache directory, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assoc_cache_counter_replacement_defines.svh"

module acr_checker (
   input wire logic clock,
   input wire logic reset,
   input wire logic start,
   input wire logic busy,
   input wire logic rsp_valid,
   input wire logic rsp_hit,
   input wire logic rsp_evicted_valid
);

   `ACR_ASSERT(a_accept_goes_busy, start && !busy |=> busy, "accepted item did not raise busy")
   `ACR_ASSERT_ALWAYS(a_result_while_busy, rsp_valid |-> busy, "result strobe outside an item")
   `ACR_ASSERT(a_single_result, rsp_valid |=> !rsp_valid, "result strobe longer than one cycle")
   `ACR_ASSERT(a_done_with_result, $fell(busy) && !$past(reset) |-> $past(rsp_valid), "item ended without a result")
   `ACR_ASSERT(a_hit_no_evict, rsp_valid && rsp_hit |-> !rsp_evicted_valid, "eviction reported on a hit")

endmodule

bind assoc_cache_counter_replacement acr_checker u_acr_checker (
   .clock             (clock),
   .reset             (reset),
   .start             (start),
   .busy              (busy),
   .rsp_valid         (rsp_valid),
   .rsp_hit           (rsp_hit),
   .rsp_evicted_valid (rsp_evicted_valid)
);

`default_nettype wire
